// ===== src/ptcc_pkg.sv =====
// shared types and constants of the point transform, crop and colorize block
// no dependencies

package ptcc_pkg;

  // matrix entry format, signed q2.16
  localparam int MAT_BITS = 18;
  localparam int MAT_FRAC = 16;
  localparam int ROW_W    = 3 * MAT_BITS;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_ROW0 = 3'd0,
    REG_ROT_ROW1 = 3'd1,
    REG_ROT_ROW2 = 3'd2,
    REG_SHIFT_XY = 3'd3,
    REG_SHIFT_Z  = 3'd4
  } cfg_reg_t;

  // identity matrix rows after reset
  localparam logic [ROW_W-1:0] ROT_ROW0_RST = ROW_W'(1) << MAT_FRAC;
  localparam logic [ROW_W-1:0] ROT_ROW1_RST = ROW_W'(1) << (MAT_FRAC + MAT_BITS);
  localparam logic [ROW_W-1:0] ROT_ROW2_RST = ROW_W'(1) << (MAT_FRAC + 2 * MAT_BITS);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam logic [7:0] LVL_OFF  = 8'd0;
  localparam logic [7:0] LVL_HALF = 8'd125;
  localparam logic [7:0] LVL_FULL = 8'd255;

  localparam rgb_t CLR_BLUE    = '{red: LVL_OFF,  green: LVL_OFF,  blue: LVL_FULL};
  localparam rgb_t CLR_GREEN   = '{red: LVL_OFF,  green: LVL_FULL, blue: LVL_OFF};
  localparam rgb_t CLR_RED     = '{red: LVL_FULL, green: LVL_OFF,  blue: LVL_OFF};
  localparam rgb_t CLR_CYAN    = '{red: LVL_OFF,  green: LVL_FULL, blue: LVL_FULL};
  localparam rgb_t CLR_YELLOW  = '{red: LVL_FULL, green: LVL_FULL, blue: LVL_OFF};
  localparam rgb_t CLR_MAGENTA = '{red: LVL_FULL, green: LVL_OFF,  blue: LVL_FULL};
  localparam rgb_t CLR_BLACK   = '{red: LVL_OFF,  green: LVL_OFF,  blue: LVL_OFF};
  localparam rgb_t CLR_GREY    = '{red: LVL_HALF, green: LVL_HALF, blue: LVL_HALF};
  localparam rgb_t CLR_WHITE   = '{red: LVL_FULL, green: LVL_FULL, blue: LVL_FULL};

endpackage

// ===== src/ptcc_if.sv =====
// valid/ready channel interfaces for camera points in and colored points out
// no dependencies

interface ptcc_in_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] raw_x;
  logic signed [COORD_WIDTH-1:0] raw_y;
  logic signed [COORD_WIDTH-1:0] raw_z;

  modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
  modport sink   (input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

interface ptcc_out_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic [7:0]                    red;
  logic [7:0]                    green;
  logic [7:0]                    blue;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output red, output green, output blue, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input red, input green, input blue, output ready);
endinterface

// ===== src/point_transform_crop_colorize.sv =====
// top level: rigid transform, crop box and height band coloring of 3d points
// depends on ptcc_pkg, ptcc_if, ptcc_mul, ptcc_acc, ptcc_crop
// an accepted word passes the input, product, sum and output registers in turn
// throughput: a point per clock unless stalled, set by the four stage pipeline
// reset (rst, synchronous) empties the pipeline and loads the identity matrix
// and zero translation; points that fall outside the box produce no word

module point_transform_crop_colorize #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 16,
  localparam int CFG_W = (2 * COORD_WIDTH > ptcc_pkg::ROW_W) ? 2 * COORD_WIDTH
                                                             : ptcc_pkg::ROW_W
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [ptcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  ptcc_in_if.sink                        pt_in,
  ptcc_out_if.source                     pt_out
);
  import ptcc_pkg::*;

  localparam int PROD_W = MAT_BITS + COORD_WIDTH;

  // configuration registers
  logic [ROW_W-1:0]         rot [3];
  logic [2*COORD_WIDTH-1:0] shift_xy;
  logic [COORD_WIDTH-1:0]   shift_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot[0]   <= ROT_ROW0_RST;
      rot[1]   <= ROT_ROW1_RST;
      rot[2]   <= ROT_ROW2_RST;
      shift_xy <= '0;
      shift_z  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ROT_ROW0: rot[0]   <= cfg_data[ROW_W-1:0];
        REG_ROT_ROW1: rot[1]   <= cfg_data[ROW_W-1:0];
        REG_ROT_ROW2: rot[2]   <= cfg_data[ROW_W-1:0];
        REG_SHIFT_XY: shift_xy <= cfg_data[2*COORD_WIDTH-1:0];
        REG_SHIFT_Z:  shift_z  <= cfg_data[COORD_WIDTH-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // stage occupancy and advance; a stage moves when the next one is empty
  // or moving, so bubbles from cropped points collapse
  logic v0, v1, v2, v3;
  logic en0, en1, en2, en3;

  assign en3 = !v3 || pt_out.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;

  assign pt_in.ready = en0;

  // stage 0: input register
  logic signed [COORD_WIDTH-1:0] pnt [3];

  always_ff @(posedge clk) begin
    if (en0) begin
      pnt[0] <= pt_in.raw_x;
      pnt[1] <= pt_in.raw_y;
      pnt[2] <= pt_in.raw_z;
    end
  end

  // stage 1: products
  logic signed [PROD_W-1:0] prod [3][3];

  ptcc_mul #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_mul (
    .clk  (clk),
    .en   (en1),
    .rot  (rot),
    .pnt  (pnt),
    .prod (prod)
  );

  // stage 2: sums, translation, saturation
  logic signed [COORD_WIDTH-1:0] trans [3];
  logic signed [COORD_WIDTH-1:0] pos [3];

  assign trans[0] = shift_xy[COORD_WIDTH-1:0];
  assign trans[1] = shift_xy[2*COORD_WIDTH-1:COORD_WIDTH];
  assign trans[2] = shift_z;

  ptcc_acc #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_acc (
    .clk   (clk),
    .en    (en2),
    .prod  (prod),
    .trans (trans),
    .pos   (pos)
  );

  // stage 3: crop test and color, then the output register
  logic keep;
  rgb_t color;

  ptcc_crop #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_crop (
    .pos_x (pos[0]),
    .pos_y (pos[1]),
    .pos_z (pos[2]),
    .keep  (keep),
    .color (color)
  );

  logic signed [COORD_WIDTH-1:0] out_pos [3];
  rgb_t                          out_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en0) v0 <= pt_in.valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2 && keep;  // cropped points leave here
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_pos   <= pos;
      out_color <= color;
    end
  end

  assign pt_out.valid = v3;
  assign pt_out.pos_x = out_pos[0];
  assign pt_out.pos_y = out_pos[1];
  assign pt_out.pos_z = out_pos[2];
  assign pt_out.red   = out_color.red;
  assign pt_out.green = out_color.green;
  assign pt_out.blue  = out_color.blue;

`ifndef SYNTHESIS
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !pt_in.ready |-> (v0 && v1 && v2 && v3))
    else $error("input blocked while a pipeline stage is empty");

  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    (v1 && !en2) |=> v1)
    else $error("stalled product stage lost its word");

  a_stage2_hold: assert property (@(posedge clk) disable iff (rst)
    (v2 && !en3) |=> (v2 && $stable(pos[1])))
    else $error("stalled sum stage changed or lost its word");

  a_color_levels: assert property (@(posedge clk) disable iff (rst)
    pt_out.valid |-> ((pt_out.red == LVL_OFF || pt_out.red == LVL_HALF ||
                       pt_out.red == LVL_FULL) &&
                      (pt_out.green == pt_out.red || pt_out.red != LVL_HALF)))
    else $error("output color not from the band table");
`endif

endmodule

// ===== src/ptcc_mul.sv =====
// product stage: nine matrix entry times coordinate products, registered
// depends on ptcc_pkg

module ptcc_mul #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                                          clk,
  input  logic                                          en,
  input  logic [ptcc_pkg::ROW_W-1:0]                    rot [3],
  input  logic signed [COORD_WIDTH-1:0]                 pnt [3],
  output logic signed [ptcc_pkg::MAT_BITS+COORD_WIDTH-1:0] prod [3][3]
);
  import ptcc_pkg::*;

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      logic signed [MAT_BITS-1:0] coef;
      assign coef = $signed(rot[r][MAT_BITS*c +: MAT_BITS]);

      always_ff @(posedge clk) begin
        if (en) begin
          prod[r][c] <= coef * pnt[c];
        end
      end
    end
  end

endmodule

// ===== src/ptcc_acc.sv =====
// sum stage: row sums plus translation, floor to point format, saturation
// depends on ptcc_pkg

module ptcc_acc #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                                             clk,
  input  logic                                             en,
  input  logic signed [ptcc_pkg::MAT_BITS+COORD_WIDTH-1:0] prod [3][3],
  input  logic signed [COORD_WIDTH-1:0]                    trans [3],
  output logic signed [COORD_WIDTH-1:0]                    pos [3]
);
  import ptcc_pkg::*;

  localparam int PROD_W = MAT_BITS + COORD_WIDTH;
  localparam int ACC_W  = PROD_W + 2;

  localparam logic signed [ACC_W-1:0] MAXV =
    {{(ACC_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] MINV = ~MAXV;

  for (genvar r = 0; r < 3; r++) begin : g_row
    logic signed [ACC_W-1:0]       sum;
    logic signed [ACC_W-1:0]       tsh;
    logic signed [ACC_W-1:0]       flr;
    logic signed [COORD_WIDTH-1:0] sat;

    assign tsh = {{(ACC_W-COORD_WIDTH-MAT_FRAC){trans[r][COORD_WIDTH-1]}},
                  trans[r], {MAT_FRAC{1'b0}}};
    assign sum = ACC_W'(prod[r][0]) + ACC_W'(prod[r][1]) + ACC_W'(prod[r][2]) + tsh;
    // arithmetic shift rounds toward minus infinity
    assign flr = sum >>> MAT_FRAC;

    always_comb begin
      if (flr > MAXV) begin
        sat = MAXV[COORD_WIDTH-1:0];
      end else if (flr < MINV) begin
        sat = MINV[COORD_WIDTH-1:0];
      end else begin
        sat = flr[COORD_WIDTH-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pos[r] <= sat;
      end
    end
  end

endmodule

// ===== src/ptcc_crop.sv =====
// crop box test on x and z and height band color from y
// depends on ptcc_pkg

module ptcc_crop #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic signed [COORD_WIDTH-1:0] pos_z,
  output logic                          keep,
  output ptcc_pkg::rgb_t                color
);
  import ptcc_pkg::*;

  // bounds in milli-units, v*1000 compared against k*2^frac
  localparam longint U    = longint'(1) << FRAC_BITS;
  localparam longint C300 = (300 * U + 999) / 1000;
  localparam longint F150 = (150 * U) / 1000;
  localparam longint F5   = (5 * U) / 1000;
  localparam longint F10  = (10 * U) / 1000;
  localparam longint F15  = (15 * U) / 1000;
  localparam longint F20  = (20 * U) / 1000;
  localparam longint F30  = (30 * U) / 1000;
  localparam longint C5   = (5 * U + 999) / 1000;
  localparam longint C10  = (10 * U + 999) / 1000;

  localparam int CMP_W = (COORD_WIDTH > 20 ? COORD_WIDTH : 20) + 1;

  localparam logic signed [CMP_W-1:0] LIM_HI   = CMP_W'(C300);
  localparam logic signed [CMP_W-1:0] LIM_LO   = CMP_W'(-C300);
  localparam logic signed [CMP_W-1:0] LIM_ZLO  = CMP_W'(F150);
  localparam logic signed [CMP_W-1:0] BND_N5   = CMP_W'(-F5);
  localparam logic signed [CMP_W-1:0] BND_N10  = CMP_W'(-F10);
  localparam logic signed [CMP_W-1:0] BND_N15  = CMP_W'(-F15);
  localparam logic signed [CMP_W-1:0] BND_N20  = CMP_W'(-F20);
  localparam logic signed [CMP_W-1:0] BND_N30  = CMP_W'(-F30);
  localparam logic signed [CMP_W-1:0] BND_P5   = CMP_W'(C5);
  localparam logic signed [CMP_W-1:0] BND_P10  = CMP_W'(C10);
  localparam logic signed [CMP_W-1:0] ZERO     = '0;

  logic signed [CMP_W-1:0] xw;
  logic signed [CMP_W-1:0] yw;
  logic signed [CMP_W-1:0] zw;

  assign xw = {{(CMP_W-COORD_WIDTH){pos_x[COORD_WIDTH-1]}}, pos_x};
  assign yw = {{(CMP_W-COORD_WIDTH){pos_y[COORD_WIDTH-1]}}, pos_y};
  assign zw = {{(CMP_W-COORD_WIDTH){pos_z[COORD_WIDTH-1]}}, pos_z};

  assign keep = (zw < LIM_HI) && (zw > LIM_ZLO) && (xw < LIM_HI) && (xw > LIM_LO);

  always_comb begin
    if (yw > ZERO) begin
      if (yw < BND_P5) begin
        color = CLR_BLACK;
      end else if (yw < BND_P10) begin
        color = CLR_GREY;
      end else begin
        color = CLR_WHITE;
      end
    end else if (yw >= BND_N5) begin
      color = CLR_BLUE;
    end else if (yw >= BND_N10) begin
      color = CLR_GREEN;
    end else if (yw >= BND_N15) begin
      color = CLR_RED;
    end else if (yw >= BND_N20) begin
      color = CLR_CYAN;
    end else if (yw >= BND_N30) begin
      color = CLR_YELLOW;
    end else begin
      color = CLR_MAGENTA;
    end
  end

endmodule

// ===== test/point_check_pkg.sv =====
`timescale 1ns / 100ps
// kept point tracker: predicts the colored point words of the transform, crop and colorize block
// depends on ptcc_pkg

package point_check_pkg;
  import ptcc_pkg::*;

  localparam int COORD_W = 24;
  localparam int FRAC_W  = 16;
  localparam int CFG_W   = (2 * COORD_W > ROW_W) ? 2 * COORD_W : ROW_W;

  localparam longint COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    rgb_t   color;
  } colored_point_t;

  class kept_point_tracker;
    logic [ROW_W-1:0] rot [3];
    coord_t           shift [3];
    colored_point_t   kept_points [$];
    int unsigned      mismatches;
    int unsigned      words_seen;

    function new();
      rot[0] = ROT_ROW0_RST;
      rot[1] = ROT_ROW1_RST;
      rot[2] = ROT_ROW2_RST;
      foreach (shift[i]) shift[i] = '0;
      mismatches = 0;
      words_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_ROT_ROW0: rot[0] = data[ROW_W-1:0];
        REG_ROT_ROW1: rot[1] = data[ROW_W-1:0];
        REG_ROT_ROW2: rot[2] = data[ROW_W-1:0];
        REG_SHIFT_XY: begin
          shift[0] = data[COORD_W-1:0];
          shift[1] = data[2*COORD_W-1:COORD_W];
        end
        REG_SHIFT_Z: shift[2] = data[COORD_W-1:0];
        default: ;
      endcase
    endfunction

    // one row of r * p + t, floored to the point format and saturated
    function longint transform_axis(int r, longint px, longint py, longint pz);
      longint m0, m1, m2, acc;
      m0 = longint'($signed(rot[r][0 +: MAT_BITS]));
      m1 = longint'($signed(rot[r][MAT_BITS +: MAT_BITS]));
      m2 = longint'($signed(rot[r][2*MAT_BITS +: MAT_BITS]));
      acc = m0 * px + m1 * py + m2 * pz + (longint'(shift[r]) <<< MAT_FRAC);
      acc = acc >>> MAT_FRAC;
      if (acc > COORD_MAX) acc = COORD_MAX;
      else if (acc < COORD_MIN) acc = COORD_MIN;
      return acc;
    endfunction

    // bands compared exactly against the decimal bounds, scaled by 1000
    function rgb_t height_color(longint y);
      longint s, u;
      s = y * 1000;
      u = 64'sd1 <<< FRAC_W;
      if (s >= -5 * u && s <= 0) return CLR_BLUE;
      if (s >= -10 * u && s < -5 * u) return CLR_GREEN;
      if (s >= -15 * u && s < -10 * u) return CLR_RED;
      if (s >= -20 * u && s < -15 * u) return CLR_CYAN;
      if (s >= -30 * u && s < -20 * u) return CLR_YELLOW;
      if (s < -30 * u) return CLR_MAGENTA;
      if (s < 5 * u) return CLR_BLACK;
      if (s < 10 * u) return CLR_GREY;
      return CLR_WHITE;
    endfunction

    function void note_point(coord_t rx, coord_t ry, coord_t rz);
      longint px, py, pz, x, y, z, u;
      colored_point_t pt;
      px = longint'(rx);
      py = longint'(ry);
      pz = longint'(rz);
      x = transform_axis(0, px, py, pz);
      y = transform_axis(1, px, py, pz);
      z = transform_axis(2, px, py, pz);
      u = 64'sd1 <<< FRAC_W;
      if (z * 1000 < 300 * u && z * 1000 > 150 * u &&
          x * 1000 < 300 * u && x * 1000 > -300 * u) begin
        pt.x = coord_t'(x);
        pt.y = coord_t'(y);
        pt.z = coord_t'(z);
        pt.color = height_color(y);
        kept_points = {kept_points, pt};
      end
    endfunction

    function void compare_field(string name, logic signed [63:0] want, logic signed [63:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(coord_t x, coord_t y, coord_t z,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b);
      colored_point_t want;
      words_seen++;
      if (kept_points.size() == 0) begin
        $error("unexpected word: pos_x %0d pos_y %0d pos_z %0d", x, y, z);
        mismatches++;
        return;
      end
      want = kept_points.pop_front();
      compare_field("pos_x", 64'(want.x), 64'(x));
      compare_field("pos_y", 64'(want.y), 64'(y));
      compare_field("pos_z", 64'(want.z), 64'(z));
      compare_field("red", 64'(want.color.red), 64'(r));
      compare_field("green", 64'(want.color.green), 64'(g));
      compare_field("blue", 64'(want.color.blue), 64'(b));
    endfunction

    function int waiting();
      return kept_points.size();
    endfunction
  endclass

endpackage

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// testbench top for point_transform_crop_colorize: clock, reset, drivers, checks, watchdog
// depends on ptcc_pkg, ptcc_if, point_check_pkg and the block itself

module tb_top;
  import ptcc_pkg::*;
  import point_check_pkg::*;

  localparam int ITEM_TARGET  = 1050;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_PCT     = 15;

  // q16 values right at the crop box edges
  localparam int Z_IN_LO  = 9831;
  localparam int Z_IN_HI  = 19660;
  localparam int X_IN_MAX = 19660;
  localparam int Z_MID    = 15000;

  // matrix entries: largest, most negative, one
  localparam logic [MAT_BITS-1:0] ENT_MAX = 18'h1ffff;
  localparam logic [MAT_BITS-1:0] ENT_MIN = 18'h20000;
  localparam logic [MAT_BITS-1:0] ENT_ONE = 18'h10000;

  localparam coord_t C_MAX = 24'h7fffff;
  localparam coord_t C_MIN = 24'h800000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  ptcc_in_if  #(.COORD_WIDTH(COORD_W)) cam_bus ();
  ptcc_out_if #(.COORD_WIDTH(COORD_W)) color_bus ();

  point_transform_crop_colorize #(
    .COORD_WIDTH(COORD_W),
    .FRAC_BITS  (FRAC_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pt_in    (cam_bus),
    .pt_out   (color_bus)
  );

  kept_point_tracker board;
  bit                calm;          // no idling on either side while set
  int unsigned       sent;
  int unsigned       idle_run = 0;
  longint            diag [3];      // diagonal of the current matrix, used to aim points
  longint            offs [3];      // current translation

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offer one point word, with random idle cycles in front, and log it on accept
  task automatic send_point(input coord_t x, input coord_t y, input coord_t z);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      cam_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cam_bus.valid <= 1'b1;
    cam_bus.raw_x <= x;
    cam_bus.raw_y <= y;
    cam_bus.raw_z <= z;
    @(posedge clk);
    while (!cam_bus.ready) @(posedge clk);
    // accepted at this edge, config is stable while points flow
    board.note_point(x, y, z);
    sent++;
  endtask

  // leaves the write enable high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    board.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic load_config(input logic [CFG_W-1:0] r0, input logic [CFG_W-1:0] r1,
                             input logic [CFG_W-1:0] r2, input logic [CFG_W-1:0] sxy,
                             input logic [CFG_W-1:0] sz);
    write_reg(REG_ROT_ROW0, r0);
    write_reg(REG_ROT_ROW1, r1);
    write_reg(REG_ROT_ROW2, r2);
    write_reg(REG_SHIFT_XY, sxy);
    write_reg(REG_SHIFT_Z, sz);
    cfg_wr_en <= 1'b0;
  endtask

  // wait for every kept word, then for points dropped by the box still in flight
  task automatic settle();
    cam_bus.valid <= 1'b0;
    while (board.waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // kind 0..6: near-diagonal matrix with small cross terms and small shift
  // kind 7: entries and shifts at their extremes, 8..9: fully random bits
  task automatic pick_config(input int kind);
    logic [MAT_BITS-1:0] e [3][3];
    coord_t              t [3];
    int                  mag;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (kind < 7) begin
          if (r == c) begin
            mag = $urandom_range(32768, 130000);
            e[r][c] = $urandom_range(1) ? MAT_BITS'(-mag) : MAT_BITS'(mag);
          end else begin
            e[r][c] = MAT_BITS'(int'($urandom_range(0, 1310)) - 655);
          end
        end else if (kind == 7) begin
          case ($urandom_range(3))
            0:       e[r][c] = ENT_MAX;
            1:       e[r][c] = ENT_MIN;
            2:       e[r][c] = '0;
            default: e[r][c] = ENT_ONE;
          endcase
        end else begin
          e[r][c] = MAT_BITS'($urandom);
        end
      end
      if (kind < 7) begin
        t[r] = coord_t'(int'($urandom_range(0, 65536)) - 32768);
      end else if (kind == 7) begin
        case ($urandom_range(2))
          0:       t[r] = C_MAX;
          1:       t[r] = C_MIN;
          default: t[r] = '0;
        endcase
      end else begin
        t[r] = coord_t'($urandom);
      end
      diag[r] = longint'($signed(e[r][r]));
      offs[r] = longint'(t[r]);
    end
    // now and then a write to an unused index, which must change nothing
    if ($urandom_range(3) == 0)
      write_reg(CFG_IDX_W'(REG_SHIFT_Z + 1 + $urandom_range(2)),
                CFG_W'({$urandom, $urandom}));
    // junk above the register widths must be dropped
    load_config({e[0][2], e[0][1], e[0][0]},
                {e[1][2], e[1][1], e[1][0]},
                {e[2][2], e[2][1], e[2][0]},
                {6'($urandom), t[1], t[0]},
                {30'($urandom), t[2]});
  endtask

  // aim at the crop box through the matrix diagonal; cross terms push some out
  task automatic send_aimed();
    longint tgt [3];
    coord_t raw [3];
    tgt[0] = longint'($urandom_range(0, 46000)) - 23000;
    tgt[1] = longint'($urandom_range(0, 5200)) - 2600;
    tgt[2] = longint'($urandom_range(8500, 21000));
    for (int r = 0; r < 3; r++) begin
      if (diag[r] == 0) raw[r] = coord_t'(tgt[r]);
      else raw[r] = coord_t'(((tgt[r] - offs[r]) <<< MAT_FRAC) / diag[r]);
    end
    send_point(raw[0], raw[1], raw[2]);
  endtask

  // ---------------------------------------------------------------------------
  // output side: random backpressure and the word checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    color_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && color_bus.valid && color_bus.ready)
      board.check_word(color_bus.pos_x, color_bus.pos_y, color_bus.pos_z,
                       color_bus.red, color_bus.green, color_bus.blue);
  end

  // watchdog: too long without any word moving on either side
  always @(posedge clk) begin
    if ((cam_bus.valid && cam_bus.ready) || (color_bus.valid && color_bus.ready))
      idle_run <= 0;
    else
      idle_run <= idle_run + 1;
    if (idle_run >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int phase;
    int len;
    board = new();
    calm = 1'b0;
    sent = 0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cam_bus.valid = 1'b0;
    cam_bus.raw_x = '0;
    cam_bus.raw_y = '0;
    cam_bus.raw_z = '0;
    color_bus.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // identity matrix from reset: every height band and both sides of each bound
    send_point('0, '0, coord_t'(Z_MID));              // y zero counts as blue
    send_point('0, coord_t'(-327), coord_t'(Z_MID));  // blue, lowest
    send_point('0, coord_t'(-328), coord_t'(Z_MID));  // green
    send_point('0, coord_t'(-655), coord_t'(Z_MID));
    send_point('0, coord_t'(-656), coord_t'(Z_MID));  // red
    send_point('0, coord_t'(-983), coord_t'(Z_MID));
    send_point('0, coord_t'(-984), coord_t'(Z_MID));  // cyan
    send_point('0, coord_t'(-1310), coord_t'(Z_MID));
    send_point('0, coord_t'(-1311), coord_t'(Z_MID)); // yellow
    send_point('0, coord_t'(-1966), coord_t'(Z_MID));
    send_point('0, coord_t'(-1967), coord_t'(Z_MID)); // magenta
    send_point('0, coord_t'(1), coord_t'(Z_MID));     // black
    send_point('0, coord_t'(327), coord_t'(Z_MID));
    send_point('0, coord_t'(328), coord_t'(Z_MID));   // grey
    send_point('0, coord_t'(655), coord_t'(Z_MID));
    send_point('0, coord_t'(656), coord_t'(Z_MID));   // white
    // crop box edges, open on both sides
    send_point('0, '0, coord_t'(Z_IN_LO - 1));
    send_point('0, '0, coord_t'(Z_IN_LO));
    send_point('0, '0, coord_t'(Z_IN_HI));
    send_point('0, '0, coord_t'(Z_IN_HI + 1));
    send_point(coord_t'(X_IN_MAX), '0, coord_t'(Z_MID));
    send_point(coord_t'(X_IN_MAX + 1), '0, coord_t'(Z_MID));
    send_point(coord_t'(-X_IN_MAX), '0, coord_t'(Z_MID));
    send_point(coord_t'(-X_IN_MAX - 1), '0, coord_t'(Z_MID));
    send_point(C_MAX, C_MAX, C_MAX);
    send_point(C_MIN, C_MIN, C_MIN);
    settle();

    // saturation of y while x and z sit in the box: x = 0, z = shift only
    load_config('0, {ENT_MAX, ENT_MAX, ENT_MAX}, '0, '0, CFG_W'(Z_MID));
    send_point(C_MAX, C_MAX, C_MAX);
    send_point(C_MIN, C_MIN, C_MIN);
    send_point(coord_t'(1), coord_t'(1), coord_t'(1));
    settle();
    load_config('0, {ENT_MIN, ENT_MIN, ENT_MIN}, '0, CFG_W'({C_MAX, 24'h0}),
                CFG_W'(Z_MID));
    send_point(C_MAX, C_MAX, C_MAX);
    send_point(C_MIN, C_MIN, C_MIN);
    send_point('0, '0, '0);
    settle();

    // random phases: mostly aimed points, the rest raw noise over all bits
    phase = 0;
    while (sent < ITEM_TARGET) begin
      pick_config($urandom_range(9));
      calm = (phase == 2);
      len = calm ? 300 : $urandom_range(30, 90);
      repeat (len) begin
        if ($urandom_range(99) < 75) send_aimed();
        else send_point(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
      end
      settle();
      calm = 1'b0;
      phase++;
    end

    if (board.mismatches == 0 && board.waiting() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
